[src/ilp_pkg.sv]
// Shared types, character codes and radix table for the integer literal parser.
package ilp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGS
    } t_phase;

    // Selected radix
    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_BIN,
        RX_OCT
    } t_radix;

    // Control state carried between characters
    typedef struct packed {
        t_phase phase;
        logic   negative;
        t_radix radix;
        logic   digit_seen;
    } t_ctl;

    // Result control produced by one character
    typedef struct packed {
        logic       emit;
        logic       ok;
        logic [7:0] end_char;
    } t_res;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_ONE       = 8'h31;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_LC_A      = 8'h61;
    localparam logic [7:0] CHAR_LC_B      = 8'h62;
    localparam logic [7:0] CHAR_LC_X      = 8'h78;
    localparam logic [7:0] CASE_FOLD      = 8'h20;
    localparam logic [7:0] DIG_LETTER_MIN = 8'd17;
    localparam logic [7:0] LETTER_GAP     = 8'd7;
    localparam logic [7:0] DIG_MAX        = 8'd9;

    // Number base for each radix code
    function automatic logic [7:0] radix_of(input t_radix rx);
        logic [7:0] r;
        unique case (rx)
            RX_DEC:  r = 8'd10;
            RX_HEX:  r = 8'd16;
            RX_BIN:  r = 8'd2;
            RX_OCT:  r = 8'd8;
            default: r = 8'd10;
        endcase
        return r;
    endfunction

endpackage

[src/ilp_step.sv]
// Next-state and result logic of the parser for one character.
module ilp_step
    import ilp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [7:0]             i_char,
    input  t_ctl                   i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    output t_ctl                   o_ctl,
    output logic [VALUE_WIDTH-1:0] o_acc,
    output t_res                   o_res,
    output logic [VALUE_WIDTH-1:0] o_res_val
);

    t_radix                 rad_eff;
    logic [7:0]             rad_num;
    logic [7:0]             d_fold;
    logic [7:0]             d_sub;
    logic [7:0]             d_val;
    logic                   bad_letter;
    logic                   dig_end;
    logic [VALUE_WIDTH-1:0] dig_ext;
    logic [VALUE_WIDTH-1:0] acc_step;
    logic [VALUE_WIDTH-1:0] fin_val;

    // Radix in force for a digit in the current phase
    always_comb begin
        unique case (i_ctl.phase)
            PH_DIGS: rad_eff = i_ctl.radix;
            PH_ZERO: rad_eff = RX_OCT;
            default: rad_eff = RX_DEC;
        endcase
    end

    // Fold case, map the character onto a digit value and check it
    always_comb begin
        rad_num    = radix_of(rad_eff);
        d_fold     = (i_char >= CHAR_LC_A) ? i_char - CASE_FOLD : i_char;
        d_sub      = d_fold - CHAR_ZERO;
        bad_letter = 1'b0;
        d_val      = d_sub;
        if (d_sub >= DIG_LETTER_MIN) begin
            d_val      = d_sub - LETTER_GAP;
            bad_letter = (d_val <= DIG_MAX);
        end
        dig_end = (i_char <= CHAR_SPACE) || bad_letter || (d_val >= rad_num);
        dig_ext = {{(VALUE_WIDTH-4){1'b0}}, d_val[3:0]};
    end

    // Shift-add accumulate by the selected base
    always_comb begin
        case (rad_eff)
            RX_DEC:  acc_step = (i_acc << 3) + (i_acc << 1);
            RX_HEX:  acc_step = i_acc << 4;
            RX_BIN:  acc_step = i_acc << 1;
            default: acc_step = i_acc << 3;
        endcase
        acc_step = acc_step + dig_ext;
        fin_val  = i_ctl.negative ? (~i_acc + 1'b1) : i_acc;
    end

    // Phase decoder
    always_comb begin
        o_ctl           = i_ctl;
        o_acc           = i_acc;
        o_res.emit      = 1'b0;
        o_res.ok        = 1'b0;
        o_res.end_char  = i_char;
        o_res_val       = '0;
        unique case (i_ctl.phase)
            PH_IDLE, PH_SIGN: begin
                if (i_ctl.phase == PH_IDLE && i_char == CHAR_SPACE) begin
                    o_ctl = i_ctl;
                end else if (i_ctl.phase == PH_IDLE && i_char == CHAR_MINUS) begin
                    o_ctl.negative = 1'b1;
                    o_ctl.phase    = PH_SIGN;
                end else if (i_char == CHAR_ZERO) begin
                    o_ctl.phase = PH_ZERO;
                end else if (i_char >= CHAR_ONE && i_char <= CHAR_NINE) begin
                    // a decimal digit is always in range here
                    o_ctl.phase      = PH_DIGS;
                    o_ctl.radix      = RX_DEC;
                    o_ctl.digit_seen = 1'b1;
                    o_acc            = acc_step;
                end else begin
                    o_res.emit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_char <= CHAR_SPACE || i_char == CHAR_COMMA) begin
                    o_res.emit = 1'b1;
                    o_res.ok   = 1'b1;
                end else if (i_char == CHAR_LC_X) begin
                    o_ctl.radix = RX_HEX;
                    o_ctl.phase = PH_DIGS;
                end else if (i_char == CHAR_LC_B) begin
                    o_ctl.radix = RX_BIN;
                    o_ctl.phase = PH_DIGS;
                end else if (i_char >= CHAR_ZERO && i_char <= CHAR_NINE) begin
                    if (dig_end) begin
                        // octal-illegal digit right after the leading zero
                        o_res.emit = 1'b1;
                        o_res.ok   = i_ctl.digit_seen;
                        o_res_val  = fin_val;
                    end else begin
                        o_ctl.radix      = RX_OCT;
                        o_ctl.phase      = PH_DIGS;
                        o_ctl.digit_seen = 1'b1;
                        o_acc            = acc_step;
                    end
                end else begin
                    o_res.emit = 1'b1;
                    o_res.ok   = 1'b1;
                end
            end
            PH_DIGS: begin
                if (dig_end) begin
                    o_res.emit = 1'b1;
                    o_res.ok   = i_ctl.digit_seen;
                    o_res_val  = fin_val;
                end else begin
                    o_ctl.digit_seen = 1'b1;
                    o_acc            = acc_step;
                end
            end
            default: begin
                o_res.emit = 1'b0;
            end
        endcase
        // Return to idle after every result
        if (o_res.emit) begin
            o_ctl.phase      = PH_IDLE;
            o_ctl.negative   = 1'b0;
            o_ctl.radix      = RX_DEC;
            o_ctl.digit_seen = 1'b0;
            o_acc            = '0;
        end
    end

endmodule

[src/integer_literal_parser_core.sv]
// A result appears on the outputs in the cycle after its ending character is taken.
// Throughput: one character per cycle while ready is high; the parse step is a single pass
// into the state registers, with the accumulate done as a shift-add by the selected base.
// Input ready drops only while a result sits in the output register and is not taken.
// Reset (synchronous, active low) returns the parser to idle with a cleared
// accumulator and an empty output register.
module integer_literal_parser_core
    import ilp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic               o_ok,
    output logic [7:0]         o_end_char
);

    t_ctl                          r_ctl;
    t_ctl                          n_ctl;
    logic [VALUE_WIDTH-1:0]        r_acc;
    logic [VALUE_WIDTH-1:0]        n_acc;
    t_res                          step_res;
    logic [VALUE_WIDTH-1:0]        step_val;
    logic signed [VALUE_WIDTH-1:0] step_val_s;
    logic                          in_take;
    logic                          r_out_valid;
    logic signed [31:0]            r_value;
    logic                          r_ok;
    logic [7:0]                    r_end_char;

    ilp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_char    (i_in_char),
        .i_ctl     (r_ctl),
        .i_acc     (r_acc),
        .o_ctl     (n_ctl),
        .o_acc     (n_acc),
        .o_res     (step_res),
        .o_res_val (step_val)
    );

    // Take a request when the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;
    assign step_val_s = step_val;

    // Advance parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{phase: PH_IDLE, negative: 1'b0, radix: RX_DEC, digit_seen: 1'b0};
            r_acc <= '0;
        end else if (in_take) begin
            r_ctl <= n_ctl;
            r_acc <= n_acc;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload, sign-extended or cut to 32 bits
    always_ff @(posedge i_clk) begin
        if (in_take && step_res.emit) begin
            r_value    <= 32'(step_val_s);
            r_ok       <= step_res.ok;
            r_end_char <= step_res.end_char;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_ok        = r_ok;
    assign o_end_char  = r_end_char;

endmodule

[src/ilp_checker.sv]
// Port-level checks for the integer literal parser, bound to the top level.
module ilp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [7:0]         i_in_char,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_value,
    input logic               o_ok,
    input logic [7:0]         o_end_char
);

    // A failed parse always reports zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_value == 32'sd0))
        else $error("failed parse with nonzero value");

    // A held result blocks new requests
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is stalled");

    // A new result follows a taken request and carries its character
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && !i_out_ready) && $past(i_rst_n))
        |-> ($past(i_in_valid && o_in_ready) && o_end_char == $past(i_in_char)))
        else $error("result without matching request");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_value) && $stable(o_ok) && $stable(o_end_char)))
        else $error("stalled result changed");

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (.*);
